[hdl/bcdc_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bcdc_pkg
// Shared types, key codes and digit limits for the BCD clock with digit entry.
// ---------------------------------------------------------------------------
package bcdc_pkg;

   localparam int DIGITS = 6;

   typedef logic [3:0] digit_type;
   typedef digit_type [DIGITS-1:0] digits_type;   // index 0 = hours tens
   typedef logic [2:0] position_type;

   localparam logic [7:0] TICKS_PER_SECOND_RESET = 8'd20;

   localparam logic [4:0] NO_KEY      = 5'd16;
   localparam logic [4:0] KEY_CANCEL  = 5'd10;
   localparam logic [4:0] KEY_CONFIRM = 5'd11;
   localparam logic [4:0] KEY_SET     = 5'd12;

   localparam logic [7:0] CODE_CANCEL  = 8'h82;
   localparam logic [7:0] CODE_CONFIRM = 8'h88;
   localparam logic [7:0] CODE_SET     = 8'h84;

   // cascade limit of each digit, hours tens first
   localparam logic [4:0] DIGIT_LIMIT [DIGITS] = '{5'd10, 5'd10, 5'd6, 5'd10, 5'd6, 5'd10};

   localparam position_type LAST_POSITION = position_type'(DIGITS - 1);

   function automatic logic [4:0] decode_key(input logic [7:0] code);
      logic [4:0] key;
      unique case (code)
         8'h18:        key = 5'd0;
         8'h14:        key = 5'd1;
         8'h24:        key = 5'd2;
         8'h44:        key = 5'd3;
         8'h12:        key = 5'd4;
         8'h22:        key = 5'd5;
         8'h42:        key = 5'd6;
         8'h11:        key = 5'd7;
         8'h21:        key = 5'd8;
         8'h41:        key = 5'd9;
         CODE_CANCEL:  key = KEY_CANCEL;
         CODE_CONFIRM: key = KEY_CONFIRM;
         CODE_SET:     key = KEY_SET;
         8'h81:        key = 5'd13;
         8'h28:        key = 5'd14;
         8'h48:        key = 5'd15;
         default:      key = NO_KEY;
      endcase
      return key;
   endfunction

endpackage
`default_nettype wire

[hdl/bcdc_second_cascade.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bcdc_second_cascade
// Adds one second to hh:mm:ss BCD digits; a digit whose incremented value
// reaches or passes its limit wraps to zero and carries on.
// ---------------------------------------------------------------------------
module bcdc_second_cascade (
   input  var bcdc_pkg::digits_type digits_cur,
   output var bcdc_pkg::digits_type digits_next
);

   logic       carry;
   logic [4:0] sum;

   always_comb begin
      carry       = 1'b1;
      sum         = '0;
      digits_next = digits_cur;
      for (int i = bcdc_pkg::DIGITS - 1; i >= 0; i--) begin
         sum = {1'b0, digits_cur[i]} + 5'd1;
         if (carry) begin
            if (sum >= bcdc_pkg::DIGIT_LIMIT[i]) begin
               digits_next[i] = '0;
            end else begin
               digits_next[i] = sum[3:0];
               carry          = 1'b0;
            end
         end
      end
   end

endmodule
`default_nettype wire

[hdl/bcd_clock_with_digit_entry_unit.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bcd_clock_with_digit_entry_unit
// BCD hh:mm:ss clock driven by tick transfers, with keypad time entry.
// ---------------------------------------------------------------------------
// Each request is a tick or a raw key-matrix code and yields exactly one
// response showing the clock state after it. A request is taken every cycle
// unless req_stall is high; it is captured in the input register, and the
// next state is computed in a single pass and loaded into the state register
// that doubles as the response register. The user must write ticks_per_second
// through csr_wen/csr_wdata only while the unit is idle; the unit does not
// enforce this. A value of zero makes every tick outside set mode count one second.
module bcd_clock_with_digit_entry_unit (
   input  var logic       clock,
   input  var logic       reset,

   input  var logic       csr_wen,
   input  var logic [7:0] csr_wdata,

   input  var logic       req_valid,
   output var logic       req_stall,
   input  var logic       req_action,
   input  var logic [7:0] req_key_code,

   output var logic       rsp_valid,
   input  var logic       rsp_stall,
   output var logic [3:0] rsp_hours_tens,
   output var logic [3:0] rsp_hours_units,
   output var logic [3:0] rsp_minutes_tens,
   output var logic [3:0] rsp_minutes_units,
   output var logic [3:0] rsp_seconds_tens,
   output var logic [3:0] rsp_seconds_units,
   output var logic       rsp_setting_mode,
   output var logic [2:0] rsp_entry_position
);

   logic [7:0]                tps_val_ff;
   logic                      in_valid_ff, in_valid_in;
   logic                      in_action_ff;
   logic [7:0]                in_key_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   bcdc_pkg::digits_type      time_ff, time_in, time_tick;
   bcdc_pkg::digits_type      backup_ff, backup_in;
   logic [7:0]                tick_ff, tick_in, tick_inc;
   logic                      setting_ff, setting_in;
   bcdc_pkg::position_type    index_ff, index_in;
   logic                      move, accept_req;
   logic [4:0]                key;
   logic [3:0]                key_digit;

   assign move        = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !move;
   assign accept_req  = req_valid && !req_stall;
   assign in_valid_in = accept_req || (in_valid_ff && !move);
   assign rsp_valid_in = move || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_val_ff <= bcdc_pkg::TICKS_PER_SECOND_RESET;
      end else if (csr_wen) begin
         tps_val_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept_req) begin
         in_action_ff <= req_action;
         in_key_ff    <= req_key_code;
      end
   end

   bcdc_second_cascade u_cascade (
      .digits_cur  (time_ff),
      .digits_next (time_tick)
   );

   assign tick_inc  = tick_ff + 8'd1;
   assign key       = bcdc_pkg::decode_key(in_key_ff);
   assign key_digit = (key >= 5'd10) ? 4'(key - 5'd10) : key[3:0];

   always_comb begin
      time_in    = time_ff;
      backup_in  = backup_ff;
      tick_in    = tick_ff;
      setting_in = setting_ff;
      index_in   = index_ff;
      if (!in_action_ff) begin
         if (!setting_ff) begin
            if (tick_inc >= tps_val_ff) begin
               tick_in = '0;
               time_in = time_tick;
            end else begin
               tick_in = tick_inc;
            end
         end
      end else if (key != bcdc_pkg::NO_KEY) begin
         if (!setting_ff) begin
            if (key == bcdc_pkg::KEY_SET) begin
               backup_in  = time_ff;
               time_in    = '0;
               setting_in = 1'b1;
               index_in   = '0;
            end
         end else if (key == bcdc_pkg::KEY_CANCEL) begin
            time_in    = backup_ff;
            setting_in = 1'b0;
            index_in   = '0;
         end else if (key == bcdc_pkg::KEY_CONFIRM) begin
            setting_in = 1'b0;
            index_in   = '0;
         end else begin
            time_in[index_ff] = key_digit;
            if (index_ff >= bcdc_pkg::LAST_POSITION) begin
               setting_in = 1'b0;
               index_in   = '0;
            end else begin
               index_in = index_ff + 3'd1;
            end
         end
      end
   end

   // state doubles as the response register: it only changes on a move
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff    <= '0;
         backup_ff  <= '0;
         tick_ff    <= '0;
         setting_ff <= 1'b0;
         index_ff   <= '0;
      end else if (move) begin
         time_ff    <= time_in;
         backup_ff  <= backup_in;
         tick_ff    <= tick_in;
         setting_ff <= setting_in;
         index_ff   <= index_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hours_tens     = time_ff[0];
   assign rsp_hours_units    = time_ff[1];
   assign rsp_minutes_tens   = time_ff[2];
   assign rsp_minutes_units  = time_ff[3];
   assign rsp_seconds_tens   = time_ff[4];
   assign rsp_seconds_units  = time_ff[5];
   assign rsp_setting_mode   = setting_ff;
   assign rsp_entry_position = index_ff;

   a_entry_zero_outside_set: assert property (@(posedge clock) disable iff (reset)
      !setting_ff |-> index_ff == '0)
      else $error("entry position nonzero outside set mode");

   a_entry_in_range: assert property (@(posedge clock) disable iff (reset)
      index_ff <= bcdc_pkg::LAST_POSITION)
      else $error("entry position out of range");

   a_digits_bcd: assert property (@(posedge clock) disable iff (reset)
      time_ff[0] <= 4'd9 && time_ff[1] <= 4'd9 && time_ff[2] <= 4'd9 &&
      time_ff[3] <= 4'd9 && time_ff[4] <= 4'd9 && time_ff[5] <= 4'd9)
      else $error("time digit not BCD");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !move |=> $stable(time_ff) && $stable(setting_ff) && $stable(tick_ff))
      else $error("state changed without a transfer");

   a_csr_written: assert property (@(posedge clock) disable iff (reset)
      csr_wen |=> tps_val_ff == $past(csr_wdata))
      else $error("ticks_per_second write lost");

endmodule
`default_nettype wire

[tb/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for bcd_clock_with_digit_entry_unit.
// ---------------------------------------------------------------------------
// A directed run covers key decoding, keys outside set mode, SET/CANCEL/
// CONFIRM and entry that ends at the sixth digit. Random traffic follows:
// set sessions with near-limit digits followed by tick bursts, plain tick
// bursts and stray keys, over several ticks_per_second settings, 0 and 255
// among them. Both channels idle at random. Each response is checked field
// by field against a scoreboard that tracks the clock state itself.
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      bcdc_pkg::digits_type   digits;
      logic                   setting;
      bcdc_pkg::position_type position;
   } clock_view_type;

   localparam logic [7:0] DIGIT_CODE [10] =
      '{8'h18, 8'h14, 8'h24, 8'h44, 8'h12, 8'h22, 8'h42, 8'h11, 8'h21, 8'h41};
   // keys 12..15, which write 2..5 in set mode
   localparam logic [7:0] EXTRA_CODE [4] = '{bcdc_pkg::CODE_SET, 8'h81, 8'h28, 8'h48};
   localparam string FIELD_NAME [bcdc_pkg::DIGITS] = '{"hours_tens", "hours_units",
      "minutes_tens", "minutes_units", "seconds_tens", "seconds_units"};

   class clock_scoreboard;
      bcdc_pkg::digits_type   now_digits;
      bcdc_pkg::digits_type   saved_digits;
      logic [7:0]             prescale;
      logic [7:0]             rate;
      bit                     entering;
      bcdc_pkg::position_type cursor;
      clock_view_type         expected_views[$];
      int                     failures;
      int                     checked;
      int                     transfers_in;
      int                     seconds;
      int                     hour_wraps;
      int                     sessions;

      function new();
         now_digits   = '0;
         saved_digits = '0;
         prescale     = '0;
         rate         = bcdc_pkg::TICKS_PER_SECOND_RESET;
         entering     = 1'b0;
         cursor       = '0;
         failures     = 0;
         checked      = 0;
         transfers_in = 0;
         seconds      = 0;
         hour_wraps   = 0;
         sessions     = 0;
      endfunction

      function int pending();
         return expected_views.size();
      endfunction

      function void set_rate(input logic [7:0] value);
         rate = value;
      endfunction

      function logic [4:0] key_number(input logic [7:0] code);
         for (int i = 0; i < 10; i++)
            if (code == DIGIT_CODE[i]) return 5'(i);
         for (int i = 0; i < 4; i++)
            if (code == EXTRA_CODE[i]) return 5'(12 + i);
         if (code == bcdc_pkg::CODE_CANCEL) return bcdc_pkg::KEY_CANCEL;
         if (code == bcdc_pkg::CODE_CONFIRM) return bcdc_pkg::KEY_CONFIRM;
         return bcdc_pkg::NO_KEY;
      endfunction

      function void advance_second();
         seconds++;
         for (int i = bcdc_pkg::DIGITS - 1; i >= 0; i--) begin
            if (int'(now_digits[i]) + 1 >= int'(bcdc_pkg::DIGIT_LIMIT[i])) begin
               now_digits[i] = '0;
            end else begin
               now_digits[i] = now_digits[i] + 4'd1;
               return;
            end
         end
         hour_wraps++;
      endfunction

      function void leave_entry();
         entering = 1'b0;
         cursor   = '0;
      endfunction

      function void note_input(input logic action, input logic [7:0] code);
         logic [4:0]     key;
         clock_view_type view;
         transfers_in++;
         if (action == 1'b0) begin
            if (!entering) begin
               prescale = prescale + 8'd1;
               if (prescale >= rate) begin
                  prescale = '0;
                  advance_second();
               end
            end
         end else begin
            key = key_number(code);
            if (key != bcdc_pkg::NO_KEY) begin
               if (!entering) begin
                  if (key == bcdc_pkg::KEY_SET) begin
                     saved_digits = now_digits;
                     now_digits   = '0;
                     entering     = 1'b1;
                     cursor       = '0;
                     sessions++;
                  end
               end else if (key == bcdc_pkg::KEY_CANCEL) begin
                  now_digits = saved_digits;
                  leave_entry();
               end else if (key == bcdc_pkg::KEY_CONFIRM) begin
                  leave_entry();
               end else begin
                  now_digits[cursor] = 4'(key % 10);
                  cursor = cursor + 3'd1;
                  if (cursor >= bcdc_pkg::DIGITS) leave_entry();
               end
            end
         end
         view.digits   = now_digits;
         view.setting  = entering;
         view.position = cursor;
         expected_views.push_back(view);
      endfunction

      function void check_result(input clock_view_type got);
         clock_view_type want;
         if (expected_views.size() == 0) begin
            $error("response transfer with no request outstanding");
            failures++;
            return;
         end
         want = expected_views.pop_front();
         checked++;
         for (int i = 0; i < bcdc_pkg::DIGITS; i++)
            if (got.digits[i] !== want.digits[i]) begin
               $error("%s: expected %0d, got %0d", FIELD_NAME[i],
                      want.digits[i], got.digits[i]);
               failures++;
            end
         if (got.setting !== want.setting) begin
            $error("setting_mode: expected %0d, got %0d", want.setting, got.setting);
            failures++;
         end
         if (got.position !== want.position) begin
            $error("entry_position: expected %0d, got %0d", want.position, got.position);
            failures++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wen = 1'b0;
   logic [7:0] csr_wdata = '0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_action = 1'b0;
   logic [7:0] req_key_code = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [3:0] rsp_hours_tens;
   logic [3:0] rsp_hours_units;
   logic [3:0] rsp_minutes_tens;
   logic [3:0] rsp_minutes_units;
   logic [3:0] rsp_seconds_tens;
   logic [3:0] rsp_seconds_units;
   logic       rsp_setting_mode;
   logic [2:0] rsp_entry_position;

   clock_scoreboard sb = new();
   bit steady = 1'b0;
   int work_items = 0;
   int rate_writes = 0;

   bcd_clock_with_digit_entry_unit dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wen            (csr_wen),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_key_code       (req_key_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hours_tens     (rsp_hours_tens),
      .rsp_hours_units    (rsp_hours_units),
      .rsp_minutes_tens   (rsp_minutes_tens),
      .rsp_minutes_units  (rsp_minutes_units),
      .rsp_seconds_tens   (rsp_seconds_tens),
      .rsp_seconds_units  (rsp_seconds_units),
      .rsp_setting_mode   (rsp_setting_mode),
      .rsp_entry_position (rsp_entry_position)
   );

   always #2 clock = ~clock;

   function automatic int pause_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_item(input logic action, input logic [7:0] code, input bit counts);
      int gap;
      req_valid    <= 1'b1;
      req_action   <= action;
      req_key_code <= code;
      do @(posedge clock); while (req_stall);
      sb.note_input(action, code);
      if (counts) work_items++;
      gap = steady ? 0 : pause_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic press(input logic [7:0] code);
      send_item(1'b1, code, 1'b1);
   endtask

   task automatic tick();
      send_item(1'b0, 8'($urandom), 1'b1);
   endtask

   task automatic tick_burst(input int count);
      repeat (count) tick();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_rate(input logic [7:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      sb.set_rate(value);
      rate_writes++;
   endtask

   // set session with digits biased toward the carry limits
   task automatic entry_session();
      int stop_at;
      int v;
      press(bcdc_pkg::CODE_SET);
      stop_at = ($urandom_range(0, 9) < 7) ? bcdc_pkg::DIGITS
                                           : $urandom_range(0, bcdc_pkg::DIGITS - 1);
      for (int n = 0; n < stop_at; n++) begin
         if ($urandom_range(0, 11) == 0) begin
            if ($urandom_range(0, 1) == 0) tick();
            else send_item(1'b1, 8'($urandom), 1'b0);
         end
         v = $urandom_range(0, 9);
         if (v < 5) begin
            if (n == 2 || n == 4) v = ($urandom_range(0, 3) == 0) ? 9 : 5;
            else v = 9 - $urandom_range(0, 1);
            press(DIGIT_CODE[v]);
         end else if (v < 8) begin
            press(DIGIT_CODE[$urandom_range(0, 9)]);
         end else begin
            press(EXTRA_CODE[$urandom_range(0, 3)]);
         end
      end
      if (stop_at < bcdc_pkg::DIGITS)
         press(($urandom_range(0, 1) == 0) ? bcdc_pkg::CODE_CONFIRM : bcdc_pkg::CODE_CANCEL);
   endtask

   // response side: random stalls with calm stretches
   initial begin
      int             stall_left;
      int             calm_left;
      bit             hold;
      clock_view_type got;
      stall_left = 0;
      calm_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.digits[0] = rsp_hours_tens;
            got.digits[1] = rsp_hours_units;
            got.digits[2] = rsp_minutes_tens;
            got.digits[3] = rsp_minutes_units;
            got.digits[4] = rsp_seconds_tens;
            got.digits[5] = rsp_seconds_units;
            got.setting   = rsp_setting_mode;
            got.position  = rsp_entry_position;
            sb.check_result(got);
         end
         if (stall_left > 0) begin
            stall_left--;
            hold = 1'b1;
         end else if (calm_left > 0) begin
            calm_left--;
            hold = 1'b0;
         end else begin
            if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 120);
            stall_left = pause_len();
            hold = (stall_left > 0);
            if (hold) stall_left--;
         end
         rsp_stall <= hold;
      end
   end

   initial begin
      logic [7:0] rate_plan [7];
      int         target;
      int         r;
      rate_plan = '{8'd1, 8'd0, 8'd255, 8'd2, 8'($urandom_range(3, 40)), 8'd20,
                    8'($urandom_range(1, 255))};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, at the reset rate
      tick();
      send_item(1'b0, 8'hFF, 1'b1);
      press(8'h00);
      press(8'hFF);
      press(DIGIT_CODE[9]);
      press(bcdc_pkg::CODE_CONFIRM);
      press(bcdc_pkg::CODE_CANCEL);
      press(bcdc_pkg::CODE_SET);
      tick();
      press(DIGIT_CODE[9]);
      press(DIGIT_CODE[9]);
      press(EXTRA_CODE[0]);
      press(EXTRA_CODE[3]);
      press(EXTRA_CODE[1]);
      press(EXTRA_CODE[2]);
      press(bcdc_pkg::CODE_SET);
      press(DIGIT_CODE[0]);
      press(8'h77);
      press(bcdc_pkg::CODE_CANCEL);
      press(bcdc_pkg::CODE_SET);
      press(DIGIT_CODE[1]);
      press(bcdc_pkg::CODE_CONFIRM);
      press(DIGIT_CODE[2]);
      drain();

      foreach (rate_plan[p]) begin
         write_rate(rate_plan[p]);
         steady = ($urandom_range(0, 3) == 0);
         target = work_items + 240;
         while (work_items < target) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
               entry_session();
               tick_burst($urandom_range(5, 60));
            end else if (r < 75) begin
               tick_burst($urandom_range(1, 40));
            end else if (r < 96) begin
               send_item(1'b1, 8'($urandom), 1'b0);
            end else begin
               drain();
            end
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected responses never arrived", sb.pending());
         sb.failures++;
      end
      $display("Summary: %0d request transfers, %0d responses checked, %0d rate settings",
               sb.transfers_in, sb.checked, rate_writes);
      $display("Summary: %0d seconds counted, %0d clock wraps past 99 hours, %0d set sessions",
               sb.seconds, sb.hour_wraps, sb.sessions);
      if (sb.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

[filelist.f]
hdl/bcdc_pkg.sv
hdl/bcdc_second_cascade.sv
hdl/bcd_clock_with_digit_entry_unit.sv
tb/tb.sv
